@@ sv/omlr_pkg.sv @@
// ----------------------------------------------------------------------------
// omlr_pkg: shared definitions for the occupancy-mask lookahead ring
// Field widths, action and status codes, register indexes and the slot
// store command type used between the sequencer and the slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package omlr_pkg;

   // Fixed field widths
   localparam int ACTION_W  = 3;
   localparam int ADV_W     = 6;
   localparam int DATA_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 2;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_SET   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_GET   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_NEXT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_MOVE  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RESET = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OCCUPIED   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_HEAD_EMPTY = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BEHIND     = 3'd4;

   // Result kinds
   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_FREED = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_POSITION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ADVANCE_LIMIT  = 2'd1;

   // Advance limit after reset
   localparam logic [ADV_W-1:0] LIMIT_RESET = 6'd32;

   // Command to the slot store: store a handle, or free a slot
   typedef struct packed {
      logic set;
      logic clear;
   } slot_op_type;

endpackage

`default_nettype wire

@@ sv/omlr_scan.sv @@
// ----------------------------------------------------------------------------
// omlr_scan: rotate-and-find-first unit
// Rotates the occupancy mask so that bit 0 is the base slot and returns the
// offset of the first occupied slot at or after the base.
// ----------------------------------------------------------------------------
`default_nettype none

module omlr_scan
   import omlr_pkg::*;
#(
   parameter int SLOT_COUNT = 32,
   parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
   input  wire logic [SLOT_COUNT-1:0] mask,
   input  wire logic [IDX_W-1:0]      base,
   output logic                       found,
   output logic [IDX_W-1:0]           offset
);

   logic [SLOT_COUNT-1:0] rotated;
   logic [SLOT_COUNT-1:0] lowest;

   // Rotate: bit i of the result is the slot i steps ahead of base
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         rotated[i] = mask[IDX_W'(base + IDX_W'(i))];
      end
   end

   // Isolate the lowest set bit
   assign lowest = rotated & (~rotated + SLOT_COUNT'(1));

   // Encode the one-hot bit into an offset
   always_comb begin
      offset = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (lowest[i]) begin
            offset = offset | IDX_W'(i);
         end
      end
   end

   assign found = |mask;

endmodule

`default_nettype wire

@@ sv/omlr_slots.sv @@
// ----------------------------------------------------------------------------
// omlr_slots: slot store
// Holds one handle per slot and the occupancy mask. One index port serves
// the read, the store and the free of a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module omlr_slots
   import omlr_pkg::*;
#(
   parameter int SLOT_COUNT = 32,
   parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire slot_op_type           op,
   input  wire logic [IDX_W-1:0]      idx,
   input  wire logic [DATA_W-1:0]     wr_handle,
   output logic [DATA_W-1:0]          rd_handle,
   output logic [SLOT_COUNT-1:0]      occ
);

   logic [DATA_W-1:0]     handle_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] occ_ff;

   // Store handles; contents only count where the occupancy bit is set
   always_ff @(posedge clock) begin
      if (op.set) begin
         handle_ff[idx] <= wr_handle;
      end
   end

   // Mark slots on store, drop them on free
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (op.set) begin
         occ_ff[idx] <= 1'b1;
      end else if (op.clear) begin
         occ_ff[idx] <= 1'b0;
      end
   end

   assign rd_handle = handle_ff[idx];
   assign occ       = occ_ff;

endmodule

`default_nettype wire

@@ sv/occupancy_mask_lookahead_ring.sv @@
// ----------------------------------------------------------------------------
// occupancy_mask_lookahead_ring: timing wheel with an occupancy bitmap
// Sequencer around a shared rotate-and-find-first unit and the slot store.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   Actions: set, get, next, move, reset. Each transaction answers with zero
//   or more freed entries (rsp_kind 1) in ascending advance order and then
//   one closing reply (rsp_kind 0, rsp_last 1) with status and position.
//   Every result is shown for one cycle under rsp_valid; the receiver cannot
//   stall, so results must be taken as they come.
// Sequence and rate:
//   set, get and unknown actions: the reply is registered from the execute
//   state. next: the freed entry from execute, then the reply from reply state.
//   move and reset: freed entries one per cycle from the drain state, then
//   the reply; move with a target behind replies from execute. The drain rate
//   is set by the single find-first unit, yielding one occupied slot a cycle.
// Reset:
//   Synchronous, active high. Empties all slots, loads position 0, start
//   position 0 and advance limit 32. No clearing pass is needed.
// Configuration:
//   csr_we/csr_index/csr_wdata write start_position (0) or advance_limit (1);
//   the user must write only while no transaction is in flight (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_mask_lookahead_ring
   import omlr_pkg::*;
#(
   parameter int SLOT_COUNT = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [ACTION_W-1:0]   req_action,
   input  wire logic [ADV_W-1:0]      req_advance,
   input  wire logic [DATA_W-1:0]     req_handle,
   input  wire logic signed [DATA_W-1:0] req_target_position,
   output logic                       rsp_valid,
   output logic                       rsp_kind,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [DATA_W-1:0]          rsp_value,
   output logic signed [DATA_W-1:0]   rsp_position,
   output logic                       rsp_last,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam logic [ADV_W-1:0] SLOT_LIMIT = ADV_W'(SLOT_COUNT);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DRAIN,
      S_REPLY
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic [DATA_W-1:0] start_pos_ff;
   logic [ADV_W-1:0]  limit_ff;

   // Latched transaction
   logic [ACTION_W-1:0] act_ff;
   logic [ADV_W-1:0]    adv_ff;
   logic [DATA_W-1:0]   handle_ff;
   logic [DATA_W-1:0]   target_ff;

   // Sequencer state
   logic [DATA_W-1:0] pos_ff;
   logic [DATA_W:0]   diff_ff;
   logic              drain_all_ff;

   // Result registers
   logic                rsp_valid_ff;
   logic                rsp_kind_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0]   rsp_value_ff;
   logic [DATA_W-1:0]   rsp_position_ff;
   logic                rsp_last_ff;

   // Datapath signals
   logic [IDX_W-1:0]      pos_slot;
   logic [IDX_W-1:0]      req_slot;
   logic [IDX_W-1:0]      free_slot;
   logic [IDX_W-1:0]      slot_idx;
   logic [ADV_W-1:0]      limit_eff;
   logic                  adv_over;
   logic                  head_occ;
   logic                  req_occ;
   logic [SLOT_COUNT-1:0] occ;
   logic [SLOT_COUNT-1:0] scan_mask;
   logic                  scan_found;
   logic [IDX_W-1:0]      scan_offset;
   logic                  drain_go;
   logic [DATA_W:0]       move_diff;
   logic [DATA_W-1:0]     rd_handle;
   slot_op_type           slot_op;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_pos_ff <= '0;
         limit_ff     <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_START_POSITION: start_pos_ff <= csr_wdata;
            REG_ADVANCE_LIMIT:  limit_ff     <= csr_wdata[ADV_W-1:0];
            default: ;
         endcase
      end
   end

   // Slot addressing and range check
   assign pos_slot  = pos_ff[IDX_W-1:0];
   assign req_slot  = IDX_W'(pos_slot + adv_ff[IDX_W-1:0]);
   assign limit_eff = (limit_ff > SLOT_LIMIT) ? SLOT_LIMIT : limit_ff;
   assign adv_over  = adv_ff > limit_eff;
   assign head_occ  = occ[pos_slot];
   assign req_occ   = occ[req_slot];

   // Next looks past the head it frees; draining looks at the whole mask
   assign scan_mask = (state_ff == S_EXEC) ? (occ & ~(SLOT_COUNT'(1) << pos_slot)) : occ;

   omlr_scan #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_scan (
      .mask   (scan_mask),
      .base   (pos_slot),
      .found  (scan_found),
      .offset (scan_offset)
   );

   assign free_slot = IDX_W'(pos_slot + scan_offset);
   assign drain_go  = scan_found &&
                      (drain_all_ff || ({(DATA_W + 1 - IDX_W)'(0), scan_offset} < diff_ff));
   assign move_diff = {target_ff[DATA_W-1], target_ff} - {pos_ff[DATA_W-1], pos_ff};

   // Select the slot and command for this cycle
   always_comb begin
      slot_op  = '0;
      slot_idx = req_slot;
      unique case (state_ff)
         S_EXEC: begin
            if (act_ff == ACT_NEXT) begin
               slot_idx      = pos_slot;
               slot_op.clear = head_occ;
            end else if (act_ff == ACT_SET) begin
               slot_op.set = !adv_over && !req_occ;
            end
         end
         S_DRAIN: begin
            slot_idx      = free_slot;
            slot_op.clear = drain_go;
         end
         default: ;
      endcase
   end

   omlr_slots #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_slots (
      .clock     (clock),
      .reset     (reset),
      .op        (slot_op),
      .idx       (slot_idx),
      .wr_handle (handle_ff),
      .rd_handle (rd_handle),
      .occ       (occ)
   );

   // Sequencer: state, position and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         drain_all_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               // Latch the transaction
               if (start) begin
                  act_ff    <= req_action;
                  adv_ff    <= req_advance;
                  handle_ff <= req_handle;
                  target_ff <= req_target_position;
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               rsp_valid_ff    <= 1'b1;
               rsp_kind_ff     <= KIND_REPLY;
               rsp_status_ff   <= STATUS_OK;
               rsp_value_ff    <= '0;
               rsp_position_ff <= pos_ff;
               rsp_last_ff     <= 1'b1;
               state_ff        <= S_IDLE;
               unique case (act_ff)
                  ACT_SET: begin
                     if (adv_over) begin
                        rsp_status_ff <= STATUS_RANGE;
                     end else if (req_occ) begin
                        rsp_status_ff <= STATUS_OCCUPIED;
                     end
                  end
                  ACT_GET: begin
                     if (adv_over) begin
                        rsp_status_ff <= STATUS_RANGE;
                     end else if (req_occ) begin
                        rsp_value_ff <= rd_handle;
                     end
                  end
                  ACT_NEXT: begin
                     if (!head_occ) begin
                        rsp_status_ff <= STATUS_HEAD_EMPTY;
                     end else begin
                        // Emit the head, jump to the next occupied slot or else the start position
                        rsp_kind_ff  <= KIND_FREED;
                        rsp_value_ff <= rd_handle;
                        rsp_last_ff  <= 1'b0;
                        pos_ff       <= scan_found ? (pos_ff + DATA_W'(scan_offset))
                                                   : start_pos_ff;
                        state_ff     <= S_REPLY;
                     end
                  end
                  ACT_MOVE: begin
                     if (move_diff[DATA_W]) begin
                        rsp_status_ff <= STATUS_BEHIND;
                     end else begin
                        rsp_valid_ff <= 1'b0;
                        diff_ff      <= move_diff;
                        drain_all_ff <= 1'b0;
                        state_ff     <= S_DRAIN;
                     end
                  end
                  ACT_RESET: begin
                     rsp_valid_ff <= 1'b0;
                     diff_ff      <= '0;
                     drain_all_ff <= 1'b1;
                     state_ff     <= S_DRAIN;
                  end
                  default: ;
               endcase
            end
            S_DRAIN: begin
               // Free one slot a cycle, then load the new position
               if (drain_go) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_kind_ff     <= KIND_FREED;
                  rsp_status_ff   <= STATUS_OK;
                  rsp_value_ff    <= rd_handle;
                  rsp_position_ff <= pos_ff;
                  rsp_last_ff     <= 1'b0;
               end else begin
                  pos_ff   <= drain_all_ff ? start_pos_ff : target_ff;
                  state_ff <= S_REPLY;
               end
            end
            S_REPLY: begin
               rsp_valid_ff    <= 1'b1;
               rsp_kind_ff     <= KIND_REPLY;
               rsp_status_ff   <= STATUS_OK;
               rsp_value_ff    <= '0;
               rsp_position_ff <= pos_ff;
               rsp_last_ff     <= 1'b1;
               state_ff        <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Hold busy while in reset so no transaction counts as taken
   assign busy         = reset || (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

@@ sv/omlr_checker.sv @@
// ----------------------------------------------------------------------------
// omlr_checker: port-level checks for the lookahead ring
// Watches the command and result ports and checks how results line up with
// busy and with each other.
// ----------------------------------------------------------------------------
`default_nettype none

module omlr_checker
   import omlr_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic                rsp_kind,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                rsp_last
);

   // An accepted transaction holds the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a transaction");

   // No result comes out in the cycle right after an accept
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result shown right after accept");

   // A closing reply ends the transaction: the block is free again
   a_reply_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (!busy && rsp_kind == KIND_REPLY))
      else $error("closing reply while busy or with wrong kind");

   // A freed entry is never the end: more results follow
   a_freed_more: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (busy && rsp_kind == KIND_FREED &&
                                    rsp_status == STATUS_OK))
      else $error("freed entry malformed or with no closing reply pending");

endmodule

bind occupancy_mask_lookahead_ring omlr_checker u_omlr_checker (.*);

`default_nettype wire
